// ===== sv/sprm_pkg.sv =====
`timescale 1ns / 1ps
package sprm_pkg;

  // Table size and derived widths
  localparam int unsigned MAX_PEERS  = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_PEERS);
  localparam int unsigned CNT_W      = $clog2(MAX_PEERS + 1);
  localparam int unsigned NOTE_SLOTS = 3;
  localparam int unsigned NOTE_W     = 2;

  typedef enum logic {
    CMD_JOIN  = 1'b0,
    CMD_LEAVE = 1'b1
  } cmd_e;

  // Input word
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] peer_src_port;
    logic [15:0] peer_listen_port;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [15:0] dest_src_port;
    logic [15:0] next_listen_port;
    logic        last;
  } out_word_t;

  // One ring entry
  typedef struct packed {
    logic [15:0] listen;
    logic [15:0] src;
  } entry_t;

  // Ring memory access for one cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ring_req_t;

  // Pending notification
  typedef struct packed {
    logic [15:0] dst;
    logic [15:0] nxt;
  } note_t;

endpackage

// ===== sv/sprm_ring.sv =====
`timescale 1ns / 1ps
module sprm_ring (
  input  logic                clk_i,
  input  sprm_pkg::ring_req_t req_i,
  output sprm_pkg::entry_t    rdata_o
);
  import sprm_pkg::*;

  entry_t mem_q [MAX_PEERS];
  entry_t rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sprm_seq.sv =====
`timescale 1ns / 1ps
module sprm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sprm_pkg::in_word_t   in_word_i,
  output sprm_pkg::ring_req_t  ring_req_o,
  input  sprm_pkg::entry_t     ring_rdata_i,
  output logic                 note_valid_o,
  input  logic                 note_stall_i,
  output sprm_pkg::out_word_t  note_word_o
);
  import sprm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_PUT    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [15:0]      src_q, src_d;
  logic [15:0]      key_q, key_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] old_q, old_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic             dv_q, dv_d;
  logic [IDX_W-1:0] dvi_q, dvi_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] hit_q, hit_d;
  logic [15:0]      hit_l_q, hit_l_d;
  logic [15:0]      prev_s_q, prev_s_d;
  logic [15:0]      head_l_q, head_l_d;
  logic [15:0]      head_s_q, head_s_d;
  logic [15:0]      e1_l_q, e1_l_d;
  logic [15:0]      e1_s_q, e1_s_d;
  logic [15:0]      tail_s_q, tail_s_d;
  logic [15:0]      next_l_q, next_l_d;
  note_t            notes_q [NOTE_SLOTS];
  note_t            notes_d [NOTE_SLOTS];
  logic [NOTE_W-1:0] n_q, n_d;
  logic [NOTE_W-1:0] ptr_q, ptr_d;

  logic [CNT_W-1:0] p_w;
  logic [15:0]      succ_p_w;
  logic             hit_w;
  logic             more_w;
  logic             last_w;

  // Insert position: first entry not below the key, else the end
  assign p_w      = found_q ? CNT_W'(hit_q) : old_q;
  // Successor of the new peer: displaced entry, or head on wrap
  assign succ_p_w = (p_w == old_q) ? head_l_q : hit_l_q;
  // Shared compare unit on the word read back from the ring
  assign hit_w    = (cmd_q == CMD_JOIN) ? (ring_rdata_i.listen >= key_q)
                                        : (ring_rdata_i.src == src_q);
  assign last_w   = (ptr_q == n_q - NOTE_W'(1));

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    src_d    = src_q;
    key_d    = key_q;
    count_d  = count_q;
    old_d    = old_q;
    iss_d    = iss_q;
    dv_d     = 1'b0;
    dvi_d    = dvi_q;
    found_d  = found_q;
    hit_d    = hit_q;
    hit_l_d  = hit_l_q;
    prev_s_d = prev_s_q;
    head_l_d = head_l_q;
    head_s_d = head_s_q;
    e1_l_d   = e1_l_q;
    e1_s_d   = e1_s_q;
    tail_s_d = tail_s_q;
    next_l_d = next_l_q;
    notes_d  = notes_q;
    n_d      = n_q;
    ptr_d    = ptr_q;
    more_w   = 1'b0;

    ring_req_o       = '0;
    note_valid_o     = 1'b0;
    note_word_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_word_i.cmd;
          src_d   = in_word_i.peer_src_port;
          key_d   = in_word_i.peer_listen_port;
          old_d   = count_q;
          iss_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one read a cycle over all members
        if (iss_q < old_q) begin
          ring_req_o.raddr = iss_q[IDX_W-1:0];
          dv_d  = 1'b1;
          dvi_d = iss_q[IDX_W-1:0];
          iss_d = iss_q + CNT_W'(1);
        end
        // evaluate the word read last cycle
        if (dv_q) begin
          if (dvi_q == '0) begin
            head_l_d = ring_rdata_i.listen;
            head_s_d = ring_rdata_i.src;
          end
          if (dvi_q == IDX_W'(1)) begin
            e1_l_d = ring_rdata_i.listen;
            e1_s_d = ring_rdata_i.src;
          end
          if (CNT_W'(dvi_q) + CNT_W'(1) == old_q) begin
            tail_s_d = ring_rdata_i.src;
          end
          if (!found_q) begin
            if (hit_w) begin
              found_d = 1'b1;
              hit_d   = dvi_q;
              hit_l_d = ring_rdata_i.listen;
            end else begin
              prev_s_d = ring_rdata_i.src;
            end
          end else if (dvi_q == hit_q + IDX_W'(1)) begin
            next_l_d = ring_rdata_i.listen;
          end
        end
        if (iss_q >= old_q && !dv_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        n_d = '0;
        if (cmd_q == CMD_JOIN) begin
          if ((found_q && hit_l_q == key_q) || old_q == CNT_W'(MAX_PEERS)) begin
            state_d = ST_IDLE;
          end else begin
            if (old_q == CNT_W'(1)) begin
              n_d = NOTE_W'(1);
              if (p_w == '0) begin
                notes_d[0] = '{dst: src_q, nxt: head_l_q};
              end else begin
                notes_d[0] = '{dst: head_s_q, nxt: key_q};
              end
            end else if (old_q != '0) begin
              if (p_w == '0) begin
                // new head: tail first, then the new head
                n_d = NOTE_W'(2);
                notes_d[0] = '{dst: tail_s_q, nxt: key_q};
                notes_d[1] = '{dst: src_q, nxt: head_l_q};
              end else if (p_w == CNT_W'(1) && old_q == CNT_W'(2)) begin
                // three-peer wrap
                n_d = NOTE_W'(3);
                notes_d[0] = '{dst: tail_s_q, nxt: head_l_q};
                notes_d[1] = '{dst: head_s_q, nxt: key_q};
                notes_d[2] = '{dst: src_q, nxt: succ_p_w};
              end else begin
                n_d = NOTE_W'(2);
                notes_d[0] = '{dst: prev_s_q, nxt: key_q};
                notes_d[1] = '{dst: src_q, nxt: succ_p_w};
              end
            end
            iss_d   = old_q;
            state_d = ST_SHIFT;
          end
        end else begin
          if (!found_q) begin
            state_d = ST_IDLE;
          end else if (old_q == CNT_W'(1)) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            if (hit_q == '0) begin
              n_d = NOTE_W'(1);
              if (old_q == CNT_W'(2)) begin
                notes_d[0] = '{dst: e1_s_q, nxt: 16'h0000};
              end else begin
                notes_d[0] = '{dst: tail_s_q, nxt: e1_l_q};
              end
            end else if (old_q != CNT_W'(2) &&
                         CNT_W'(hit_q) + CNT_W'(1) != old_q) begin
              n_d = NOTE_W'(1);
              notes_d[0] = '{dst: prev_s_q, nxt: next_l_q};
            end
            iss_d   = CNT_W'(hit_q) + CNT_W'(1);
            state_d = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // join moves entries up from the tail, leave moves them down
        if (cmd_q == CMD_JOIN) begin
          more_w = (iss_q > p_w);
          if (more_w) begin
            ring_req_o.raddr = IDX_W'(iss_q - CNT_W'(1));
            dv_d  = 1'b1;
            dvi_d = IDX_W'(iss_q - CNT_W'(1));
            iss_d = iss_q - CNT_W'(1);
          end
        end else begin
          more_w = (iss_q < old_q);
          if (more_w) begin
            ring_req_o.raddr = iss_q[IDX_W-1:0];
            dv_d  = 1'b1;
            dvi_d = iss_q[IDX_W-1:0];
            iss_d = iss_q + CNT_W'(1);
          end
        end
        if (dv_q) begin
          ring_req_o.we    = 1'b1;
          ring_req_o.wdata = ring_rdata_i;
          ring_req_o.waddr = (cmd_q == CMD_JOIN) ? dvi_q + IDX_W'(1)
                                                 : dvi_q - IDX_W'(1);
        end
        if (!more_w && !dv_q) begin
          if (cmd_q == CMD_JOIN) begin
            state_d = ST_PUT;
          end else begin
            count_d = old_q - CNT_W'(1);
            ptr_d   = '0;
            state_d = (n_q != '0) ? ST_EMIT : ST_IDLE;
          end
        end
      end

      ST_PUT: begin
        ring_req_o.we    = 1'b1;
        ring_req_o.waddr = p_w[IDX_W-1:0];
        ring_req_o.wdata = '{listen: key_q, src: src_q};
        count_d = old_q + CNT_W'(1);
        ptr_d   = '0;
        state_d = (n_q != '0) ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        note_valid_o                 = 1'b1;
        note_word_o.dest_src_port    = notes_q[ptr_q].dst;
        note_word_o.next_listen_port = notes_q[ptr_q].nxt;
        note_word_o.last             = last_w;
        if (!note_stall_i) begin
          ptr_d = ptr_q + NOTE_W'(1);
          if (last_w) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      dv_q    <= 1'b0;
      n_q     <= '0;
      ptr_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      dv_q    <= dv_d;
      n_q     <= n_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
    end
  end

  // Working data
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    src_q    <= src_d;
    key_q    <= key_d;
    old_q    <= old_d;
    iss_q    <= iss_d;
    dvi_q    <= dvi_d;
    hit_q    <= hit_d;
    hit_l_q  <= hit_l_d;
    prev_s_q <= prev_s_d;
    head_l_q <= head_l_d;
    head_s_q <= head_s_d;
    e1_l_q   <= e1_l_d;
    e1_s_q   <= e1_s_d;
    tail_s_q <= tail_s_d;
    next_l_q <= next_l_d;
    notes_q  <= notes_d;
  end

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PEERS))
    else $error("member count beyond table size");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ring_req_o.we)
    else $error("ring written while idle");

  a_emit_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (n_q != '0 && ptr_q < n_q))
    else $error("notification pointer out of range");

  a_put_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUT) |=> (count_q == $past(old_q) + CNT_W'(1)))
    else $error("join did not grow the ring by one");

endmodule

// ===== sv/sorted_peer_ring_membership_top.sv =====
`timescale 1ns / 1ps
// Sorted peer ring: keeps up to MAX_PEERS peers ordered by listen port and, on
// each join or leave word, emits up to three notification words (peer source
// port, successor listen port, last flag on the final one). A word passes
// through a scan over all members, a decision, a shift of the entries behind
// the change, one write for a join, one notification per cycle while the output
// is free, and the return to idle, where the next word is taken. The scan and
// the shift read the entries one at a time through the single read port of the
// ring memory. in_stall_o stays high until the last notification has moved into
// the output register, which holds one word, so the sequencer can hand over one
// notification while the consumer stalls.
module sorted_peer_ring_membership_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sprm_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sprm_pkg::out_word_t out_word_o
);
  import sprm_pkg::*;

  ring_req_t ring_req;
  entry_t    ring_rdata;
  logic      note_valid;
  logic      note_stall;
  out_word_t note_word;
  logic      out_valid_q;
  out_word_t out_word_q;

  sprm_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

  sprm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .ring_req_o   (ring_req),
    .ring_rdata_i (ring_rdata),
    .note_valid_o (note_valid),
    .note_stall_i (note_stall),
    .note_word_o  (note_word)
  );

  // Output register
  assign note_stall = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (note_valid && !note_stall) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (note_valid && !note_stall) begin
      out_word_q <= note_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
